### hw/rtl/voxel_density_splat_core_macros.svh
// Assertion macros for the voxel density splat core.
`ifndef VOXEL_DENSITY_SPLAT_CORE_MACROS_SVH
`define VOXEL_DENSITY_SPLAT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define VDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vds assertion failed");
`define VDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vds assertion failed");
`else
`define VDS_ASSERT_NOW(lbl, ante, cons)
`define VDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/vds_pkg.sv
// Shared constants, types and address helper for the voxel density splat core.
package vds_pkg;

  localparam int GRID_DIM      = 32;
  localparam int MAX_HALF_SPAN = 4;

  localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(GRID_DIM);
  localparam int NK    = 2 * MAX_HALF_SPAN + 1;
  localparam int KW    = $clog2(NK);
  localparam int SPW   = $clog2(MAX_HALF_SPAN + 1);
  localparam int CW    = 20;
  localparam int RW    = CW + 1;
  localparam int OPW   = RW + 2;
  localparam int PW    = OPW + 17;
  localparam int XW    = PW - 16;

  typedef enum logic [1:0] {
    KIND_SPLAT     = 2'd0,
    KIND_CLR_MASK  = 2'd1,
    KIND_CLR_GRID  = 2'd2,
    KIND_READ      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_INV_RES  = 3'd3,
    REG_SIZE_X   = 3'd4,
    REG_SIZE_Y   = 3'd5,
    REG_SIZE_Z   = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    MODE_SPAN  = 2'd0,
    MODE_ROUND = 2'd1,
    MODE_FLOOR = 2'd2,
    MODE_CEIL  = 2'd3
  } mul_mode_e;

  typedef struct packed {
    logic                  valid;
    mul_mode_e             mode;
    logic signed [OPW-1:0] opa;
    logic [15:0]           opb;
  } mul_req_t;

  typedef struct packed {
    logic          inb;
    logic          eq;
    logic [IW-1:0] idx;
  } axis_ent_t;

  function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] x, logic [IW-1:0] y,
                                              logic [IW-1:0] z);
    logic [AW-1:0] g;
    g = AW'(GRID_DIM);
    return (AW'(x) * g + AW'(y)) * g + AW'(z);
  endfunction

endpackage

### hw/rtl/vds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/vds_idx_unit.sv
// Shared multiplier with floor, ceil, round and span post-scaling.
module vds_idx_unit import vds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_req_t             req_i,
  output logic signed [XW-1:0] res_o
);

  logic signed [PW-1:0] prod_q;
  mul_mode_e            mode_q;
  logic signed [PW-1:0] adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SPAN;
    end else if (req_i.valid) begin
      mode_q <= req_i.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q <= $signed(req_i.opa) * $signed({1'b0, req_i.opb});
    end
  end

  always_comb begin
    adj = prod_q;
    case (mode_q)
      MODE_SPAN:  adj = prod_q >>> 1;
      MODE_ROUND: adj = prod_q[PW-1] ? prod_q + PW'(32767) : prod_q + PW'(32768);
      MODE_FLOOR: adj = prod_q;
      MODE_CEIL:  adj = prod_q + PW'(65535);
      default:    adj = prod_q;
    endcase
    res_o = XW'(adj >>> 16);
  end

endmodule

### hw/rtl/voxel_density_splat_core.sv
// Top level: sequencer, config registers and grid/mask stores of the splat core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | start_i / busy_o       | kind, pos_x/y/z, radius, weight, cell_x/y/z
//  result   | done_o (one-cycle)     | status, cell_value, cells_added
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A splat with half-span s keeps busy_o high while it walks the (2s+1)^3 cells around its
// centre, with read-modify-write accesses on the single grid port (centre included): one walk
// step per cycle, but each in-bounds cell other than the centre holds the walk for its
// read-modify-write. Either clear sweeps all 32768 entries, one per cycle. After reset both
// stores are swept with busy_o high. Results cannot be stalled; done_o shows in the cycle
// after the last busy cycle, and busy_o is low then.
`include "voxel_density_splat_core_macros.svh"
module voxel_density_splat_core import vds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           kind_i,
  input  logic signed [CW-1:0] pos_x_i,
  input  logic signed [CW-1:0] pos_y_i,
  input  logic signed [CW-1:0] pos_z_i,
  input  logic [15:0]          radius_i,
  input  logic [15:0]          weight_i,
  input  logic [4:0]           cell_x_i,
  input  logic [4:0]           cell_y_i,
  input  logic [4:0]           cell_z_i,
  output logic                 done_o,
  output logic                 status_o,
  output logic [31:0]          cell_value_o,
  output logic [9:0]           cells_added_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_SPAN, ST_SPAN_W, ST_CEN, ST_CEN_W, ST_TAB,
    ST_TAB_W, ST_CELL, ST_RMW, ST_CTR, ST_CTR_RMW, ST_READ_W
  } state_e;

  // configuration
  logic signed [CW-1:0] origin_q [3];
  logic [15:0]          inv_q;
  logic [5:0]           size_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      inv_q       <= 16'd256;
      size_q[0]   <= 6'd32;
      size_q[1]   <= 6'd32;
      size_q[2]   <= 6'd32;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        REG_INV_RES:  inv_q       <= cfg_data_i[15:0];
        REG_SIZE_X:   size_q[0]   <= cfg_data_i[5:0];
        REG_SIZE_Y:   size_q[1]   <= cfg_data_i[5:0];
        REG_SIZE_Z:   size_q[2]   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e               state_q;
  logic                 clr_grid_q, clr_mask_q;
  logic [AW-1:0]        clr_cnt_q;
  logic signed [RW-1:0] rel_q [3];
  logic [15:0]          radius_q, weight_q;
  logic [SPW-1:0]       s_q;
  logic [1:0]           axis_q;
  logic [KW-1:0]        k_q, ix_q, iy_q, iz_q;
  logic signed [XW-1:0] cen_q [3];
  axis_ent_t            tab_q [3][NK];
  logic [9:0]           added_q;
  logic [AW-1:0]        acc_addr_q;
  logic                 rd_ok_q;
  logic                 done_q, status_q;
  logic [31:0]          value_q;
  logic [9:0]           count_q;

  // shared unit
  mul_req_t             mreq;
  logic signed [XW-1:0] mres;
  logic signed [KW:0]   a_v;

  vds_idx_unit u_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .res_o  (mres)
  );

  // stores
  logic          grid_we, mask_we, mask_rd, clearing;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   grid_wdata, grid_rd;
  logic [32:0]   sum;

  vds_ram #(.WIDTH(32), .DEPTH(CELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (waddr),
    .wdata_i (grid_wdata),
    .raddr_i (raddr),
    .rdata_o (grid_rd)
  );

  vds_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (waddr),
    .wdata_i (!clearing),
    .raddr_i (raddr),
    .rdata_o (mask_rd)
  );

  function automatic logic idx_inb(logic signed [XW-1:0] v, logic [XW-1:0] lim);
    return !v[XW-1] && (unsigned'(v) < lim);
  endfunction

  logic [XW-1:0] eff [3];
  logic [KW-1:0] last_k;
  axis_ent_t     ex, ey, ez;
  logic          touch_ok, cen_ok, rmw_st, walk_end;
  logic [KW-1:0] nx_ix, nx_iy, nx_iz;
  logic [9:0]    added_inc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eff[i] = (int'(size_q[i]) > GRID_DIM) ? XW'(GRID_DIM) : XW'(size_q[i]);
    end
    last_k   = KW'({s_q, 1'b0});
    ex       = tab_q[0][ix_q];
    ey       = tab_q[1][iy_q];
    ez       = tab_q[2][iz_q];
    touch_ok = ex.inb && ey.inb && ez.inb && !(ex.eq && ey.eq && ez.eq);
    cen_ok   = idx_inb(cen_q[0], eff[0]) && idx_inb(cen_q[1], eff[1]) &&
               idx_inb(cen_q[2], eff[2]);
    // walk z fastest, then y, then x
    walk_end = 1'b0;
    nx_ix    = ix_q;
    nx_iy    = iy_q;
    nx_iz    = iz_q + KW'(1);
    if (iz_q == last_k) begin
      nx_iz = '0;
      nx_iy = iy_q + KW'(1);
      if (iy_q == last_k) begin
        nx_iy = '0;
        nx_ix = ix_q + KW'(1);
        walk_end = (ix_q == last_k);
      end
    end
    added_inc = (added_q == 10'h3FF) ? added_q : added_q + 10'd1;
  end

  // multiplier requests
  always_comb begin
    a_v        = $signed({1'b0, k_q}) - $signed({1'b0, KW'(s_q)});
    mreq.valid = 1'b0;
    mreq.mode  = MODE_SPAN;
    mreq.opa   = OPW'(rel_q[axis_q]);
    mreq.opb   = inv_q;
    case (state_q)
      ST_SPAN: begin
        mreq.valid = 1'b1;
        mreq.opa   = OPW'($signed({1'b0, radius_q}));
      end
      ST_CEN: begin
        mreq.valid = 1'b1;
        mreq.mode  = MODE_ROUND;
      end
      ST_TAB: begin
        mreq.valid = 1'b1;
        mreq.opa   = OPW'(rel_q[axis_q]) + (OPW'(a_v) <<< 8);
        if (a_v < 0) begin
          mreq.mode = MODE_CEIL;
        end else if (a_v > 0) begin
          mreq.mode = MODE_FLOOR;
        end else begin
          mreq.mode = MODE_ROUND;
        end
      end
      default: ;
    endcase
  end

  // store ports
  always_comb begin
    clearing   = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    rmw_st     = (state_q == ST_RMW) || (state_q == ST_CTR_RMW);
    sum        = {1'b0, grid_rd} + 33'(weight_q);
    grid_we    = (clearing && clr_grid_q) || (rmw_st && !mask_rd);
    mask_we    = (clearing && clr_mask_q) || (rmw_st && !mask_rd);
    waddr      = clearing ? clr_cnt_q : acc_addr_q;
    grid_wdata = clearing ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
    case (state_q)
      ST_IDLE: raddr = cell_addr(IW'(cell_x_i), IW'(cell_y_i), IW'(cell_z_i));
      ST_CELL: raddr = cell_addr(ex.idx, ey.idx, ez.idx);
      ST_CTR:  raddr = cell_addr(IW'(cen_q[0]), IW'(cen_q[1]), IW'(cen_q[2]));
      default: raddr = acc_addr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      clr_grid_q <= 1'b1;
      clr_mask_q <= 1'b1;
      clr_cnt_q  <= '0;
      s_q        <= '0;
      axis_q     <= '0;
      k_q        <= '0;
      ix_q       <= '0;
      iy_q       <= '0;
      iz_q       <= '0;
      cen_q[0]   <= '0;
      cen_q[1]   <= '0;
      cen_q[2]   <= '0;
      added_q    <= '0;
      acc_addr_q <= '0;
      rd_ok_q    <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= 1'b0;
      value_q    <= '0;
      count_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(CELLS - 1)) begin
            clr_cnt_q <= '0;
            state_q   <= ST_IDLE;
            if (state_q == ST_CLEAR) begin
              done_q   <= 1'b1;
              status_q <= 1'b0;
              value_q  <= '0;
              count_q  <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            added_q <= '0;
            axis_q  <= '0;
            k_q     <= '0;
            rd_ok_q <= (int'(cell_x_i) < GRID_DIM) && (int'(cell_y_i) < GRID_DIM) &&
                       (int'(cell_z_i) < GRID_DIM);
            case (kind_e'(kind_i))
              KIND_SPLAT: state_q <= ST_SPAN;
              KIND_CLR_MASK: begin
                clr_grid_q <= 1'b0;
                clr_mask_q <= 1'b1;
                state_q    <= ST_CLEAR;
              end
              KIND_CLR_GRID: begin
                clr_grid_q <= 1'b1;
                clr_mask_q <= 1'b0;
                state_q    <= ST_CLEAR;
              end
              default: state_q <= ST_READ_W;
            endcase
          end
        end
        ST_SPAN: state_q <= ST_SPAN_W;
        ST_SPAN_W: begin
          s_q     <= (mres > XW'(MAX_HALF_SPAN)) ? SPW'(MAX_HALF_SPAN) : SPW'(mres);
          state_q <= ST_CEN;
        end
        ST_CEN: state_q <= ST_CEN_W;
        ST_CEN_W: begin
          cen_q[axis_q] <= mres;
          k_q           <= '0;
          state_q       <= ST_TAB;
        end
        ST_TAB: state_q <= ST_TAB_W;
        ST_TAB_W: begin
          if (k_q == last_k) begin
            if (axis_q == 2'd2) begin
              ix_q    <= '0;
              iy_q    <= '0;
              iz_q    <= '0;
              state_q <= ST_CELL;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_CEN;
            end
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= ST_TAB;
          end
        end
        ST_CELL, ST_RMW: begin
          if (state_q == ST_CELL && touch_ok) begin
            acc_addr_q <= raddr;
            state_q    <= ST_RMW;
          end else begin
            if (state_q == ST_RMW && !mask_rd) begin
              added_q <= added_inc;
            end
            ix_q    <= nx_ix;
            iy_q    <= nx_iy;
            iz_q    <= nx_iz;
            state_q <= walk_end ? ST_CTR : ST_CELL;
          end
        end
        ST_CTR: begin
          if (cen_ok) begin
            acc_addr_q <= raddr;
            state_q    <= ST_CTR_RMW;
          end else begin
            done_q   <= 1'b1;
            status_q <= 1'b1;
            value_q  <= '0;
            count_q  <= added_q;
            state_q  <= ST_IDLE;
          end
        end
        ST_CTR_RMW: begin
          done_q   <= 1'b1;
          status_q <= 1'b0;
          value_q  <= '0;
          count_q  <= mask_rd ? added_q : added_inc;
          state_q  <= ST_IDLE;
        end
        ST_READ_W: begin
          done_q   <= 1'b1;
          status_q <= 1'b0;
          value_q  <= rd_ok_q ? grid_rd : 32'd0;
          count_q  <= '0;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload capture and axis table
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      rel_q[0] <= RW'(pos_x_i) - RW'(origin_q[0]);
      rel_q[1] <= RW'(pos_y_i) - RW'(origin_q[1]);
      rel_q[2] <= RW'(pos_z_i) - RW'(origin_q[2]);
      radius_q <= radius_i;
      weight_q <= weight_i;
    end
    if (state_q == ST_TAB_W) begin
      tab_q[axis_q][k_q] <= '{inb: idx_inb(mres, eff[axis_q]),
                              eq:  (mres == cen_q[axis_q]),
                              idx: IW'(mres)};
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign cell_value_o  = value_q;
  assign cells_added_o = count_q;

  `VDS_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `VDS_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `VDS_ASSERT_NOW(a_read_fields, done_o && cell_value_o != 32'd0, !status_o && cells_added_o == 10'd0)

endmodule
